@@ hw/rtl/fcd_pkg.sv @@
// fcd_pkg: shared constants, command codes and result type of the framed command decoder
`default_nettype none

package fcd_pkg;

	localparam int unsigned RING_DEPTH_DEF = 10;
	localparam int unsigned CHAR_W         = 8;
	localparam int unsigned DIGIT_W        = 4;
	localparam int unsigned TIMEOUT_W      = 23;
	localparam int unsigned WIN_LEN        = 4;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(15000);

	localparam logic [CHAR_W-1:0] CH_DELETE = 8'd127;
	localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h21;
	localparam logic [CHAR_W-1:0] CH_R      = 8'h52;
	localparam logic [CHAR_W-1:0] CH_S      = 8'h53;
	localparam logic [CHAR_W-1:0] CH_T      = 8'h54;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
	localparam logic [CHAR_W-1:0] CH_W      = 8'h57;
	localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1      = 8'h31;
	localparam logic [CHAR_W-1:0] CH_7      = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9      = 8'h39;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_RESET,
		KIND_NEW_GAME,
		KIND_MOVE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [DIGIT_W-1:0]   row;
		logic [DIGIT_W-1:0]   column;
		logic [DIGIT_W-1:0]   value;
		logic [TIMEOUT_W-1:0] alarm_ms;
	} cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcd_frame.sv @@
// fcd_frame: character ring, frame window and command check for one character
`default_nettype none

module fcd_frame import fcd_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [CHAR_W-1:0]    rx_char,
	input  logic [TIMEOUT_W-1:0] idle_timeout_ms,
	output cmd_t                 cmd
);

	localparam int unsigned DW = $clog2(RING_DEPTH);

	// ring is kept rotated so that entry 0 is always the rear slot
	logic [CHAR_W-1:0] ring_q [RING_DEPTH];
	logic [CHAR_W-1:0] ring_d [RING_DEPTH];
	// the four characters after the frame front
	logic [CHAR_W-1:0] win_q [WIN_LEN];
	logic [CHAR_W-1:0] win_d [WIN_LEN];
	// distance from front to rear
	logic [DW-1:0]     dist_q, dist_d, dist_mid;
	logic              open_q, open_d, open_mid;
	logic              armed_q, armed_d;
	logic              is_del, is_open_ch, is_close;
	logic              pat_rst, pat_new, pat_digits, sum_ok;
	logic [2:0]        sum3;

	assign is_del     = (rx_char == CH_DELETE) && (dist_q != '0);
	assign is_open_ch = (rx_char == CH_OPEN);
	assign is_close   = (rx_char == CH_CLOSE);

	always_comb begin
		ring_d     = ring_q;
		win_d      = win_q;
		dist_d     = dist_q;
		open_d     = open_q;
		armed_d    = armed_q;
		open_mid   = open_q | is_open_ch;
		dist_mid   = is_open_ch ? '0 : dist_q;
		pat_rst    = 1'b0;
		pat_new    = 1'b0;
		pat_digits = 1'b0;
		sum3       = '0;
		sum_ok     = 1'b0;
		cmd          = '0;
		cmd.kind     = KIND_NONE;
		cmd.alarm_ms = idle_timeout_ms;
		if (is_del) begin
			dist_d    = dist_q - DW'(1);
			ring_d[0] = ring_q[RING_DEPTH-1];
			for (int i = 1; i < RING_DEPTH; i++) begin
				ring_d[i] = ring_q[i-1];
			end
		end else begin
			if (is_open_ch) begin
				for (int k = 0; k < WIN_LEN; k++) begin
					win_d[k] = ring_q[k+1];
				end
			end
			if (open_mid) begin
				for (int k = 0; k < WIN_LEN; k++) begin
					if (dist_mid == DW'(k + 1)) begin
						win_d[k] = rx_char;
					end
				end
				for (int i = 0; i < RING_DEPTH - 1; i++) begin
					ring_d[i] = ring_q[i+1];
				end
				ring_d[RING_DEPTH-1] = rx_char;
				dist_d = (dist_mid == DW'(RING_DEPTH - 1)) ? '0 : dist_mid + DW'(1);
			end
			open_d = open_mid;
			if (is_close) begin
				open_d  = 1'b0;
				pat_rst = (win_d[0] == CH_R) && (win_d[1] == CH_S) &&
					(win_d[2] == CH_T) && (win_d[3] == CH_CLOSE);
				pat_new = (win_d[0] == CH_N) && (win_d[1] == CH_E) &&
					(win_d[2] == CH_W) && (win_d[3] == CH_CLOSE);
				pat_digits = (win_d[0] >= CH_1) && (win_d[0] <= CH_9) &&
					(win_d[1] >= CH_1) && (win_d[1] <= CH_9) &&
					(win_d[2] >= CH_0) && (win_d[2] <= CH_9) &&
					(win_d[3] >= CH_0) && (win_d[3] <= CH_7);
				sum3   = win_d[0][2:0] + win_d[1][2:0] + win_d[2][2:0];
				sum_ok = (sum3 == win_d[3][2:0]);
				priority if (pat_rst) begin
					cmd.kind = KIND_RESET;
				end else if (pat_new) begin
					if (armed_q) begin
						cmd.kind = KIND_NEW_GAME;
						armed_d  = 1'b0;
					end
				end else if (pat_digits && sum_ok) begin
					cmd.kind   = KIND_MOVE;
					cmd.row    = win_d[0][DIGIT_W-1:0];
					cmd.column = win_d[1][DIGIT_W-1:0];
					cmd.value  = win_d[2][DIGIT_W-1:0];
				end else begin
					cmd.kind = KIND_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			for (int k = 0; k < WIN_LEN; k++) begin
				win_q[k] <= '0;
			end
			dist_q  <= '0;
			open_q  <= 1'b0;
			armed_q <= 1'b1;
		end else if (advance) begin
			ring_q  <= ring_d;
			win_q   <= win_d;
			dist_q  <= dist_d;
			open_q  <= open_d;
			armed_q <= armed_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/fcd_out_reg.sv @@
// fcd_out_reg: result register holding one decoded command for the output channel
`default_nettype none

module fcd_out_reg import fcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	logic valid_s2;
	cmd_t cmd_s2;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_cmd   = cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s2 <= in_cmd;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/framed_command_decoder_top.sv @@
// framed_command_decoder_top: top level of the framed command decoder
//
// slave stream: one received character per transfer in s_tdata
// master stream: one decoded command per input character, kind in m_tuser,
//   move digits and idle alarm period in m_tdata
// cfg channel: writes the idle timeout; take it only while the block is idle
// data path: a character accepted into the input register has its result
//   registered in the result register, which drives the master side
// throughput: one character per cycle while m_tready does not stall the output;
//   ring, frame window and check are all updated in the cycle that moves a
//   character from the input register into the result register
// when m_tready is held low the result register keeps its command, the input
//   register still takes one more character if it is empty, then s_tready falls
// reset: ring and window cleared, no frame open, new game armed, timeout 15000
`default_nettype none

module framed_command_decoder_top import fcd_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_char
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // [3:0] move_row, [7:4] move_column,
	                                        // [11:8] move_value, [34:12] idle_alarm_ms
	output logic [1:0]           m_tuser,   // [1:0] command_kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIMEOUT_W-1:0] cfg_data
);

	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic                 res_ready;
	logic                 advance;
	cmd_t                 cmd_comb;
	cmd_t                 cmd_out;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && res_ready;
	assign s_tready  = !valid_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	fcd_frame #(
		.RING_DEPTH(RING_DEPTH)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.rx_char        (char_s1),
		.idle_timeout_ms(timeout_q),
		.cmd            (cmd_comb)
	);

	fcd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_ready (res_ready),
		.in_cmd   (cmd_comb),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_cmd  (cmd_out)
	);

	assign m_tuser = cmd_out.kind;
	assign m_tdata = {5'b0, cmd_out.alarm_ms, cmd_out.value, cmd_out.column, cmd_out.row};

`ifndef SYNTHESIS
	a_move_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_MOVE) |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'd9))
		else $error("move with row out of range");
	a_no_move_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_MOVE) |-> (m_tdata[11:0] == 12'd0))
		else $error("move digits set on a non-move command");
	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(cfg_valid && cfg_ready) |-> (m_tdata[34:12] == timeout_q))
		else $error("alarm period differs from timeout register");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire

@@ tb/sv/framed_command_decoder_top_test.sv @@
// framed_command_decoder_top_test: self-checking stream testbench for the framed command decoder
`timescale 1ns / 1ps

module framed_command_decoder_top_test;
	import fcd_pkg::*;

	localparam int unsigned DEPTH      = RING_DEPTH_DEF;
	localparam int unsigned ITEM_GOAL  = 650;
	localparam int unsigned CYCLE_CAP  = 250000;
	localparam int unsigned SETTLE_CYC = 12;

	class command_tracker;
		logic [CHAR_W-1:0]    ring [DEPTH];
		int unsigned          front;
		int unsigned          rear;
		bit                   frame_open;
		bit                   new_game_armed;
		logic [TIMEOUT_W-1:0] timeout_ms;
		cmd_t                 pending_cmds [$];
		int unsigned          mismatches;
		int unsigned          errors;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			front = 0;
			rear = 0;
			frame_open = 1'b0;
			new_game_armed = 1'b1;
			timeout_ms = TIMEOUT_RESET;
			mismatches = 0;
			errors = 0;
		endfunction

		function void set_timeout(logic [TIMEOUT_W-1:0] ms);
			timeout_ms = ms;
		endfunction

		function int unsigned pending();
			return pending_cmds.size();
		endfunction

		// update the ring for one accepted character and queue the command it gives
		function void take_char(logic [CHAR_W-1:0] c);
			cmd_t              cmd;
			logic [CHAR_W-1:0] w [WIN_LEN];
			int unsigned       r, k, v, s;
			cmd = '0;
			cmd.kind = KIND_NONE;
			cmd.alarm_ms = timeout_ms;
			if (c == CH_DELETE && rear != front) begin
				rear = (rear == 0) ? DEPTH - 1 : rear - 1;
			end else begin
				if (c == CH_OPEN) begin
					frame_open = 1'b1;
					front = rear;
				end
				if (frame_open) begin
					ring[rear] = c;
					rear = (rear + 1) % DEPTH;
				end
				if (c == CH_CLOSE) begin
					for (int i = 0; i < WIN_LEN; i++)
						w[i] = ring[(front + 1 + i) % DEPTH];
					if (w[0] == CH_R && w[1] == CH_S && w[2] == CH_T && w[3] == CH_CLOSE) begin
						cmd.kind = KIND_RESET;
					end else if (w[0] == CH_N && w[1] == CH_E && w[2] == CH_W &&
							w[3] == CH_CLOSE) begin
						if (new_game_armed) begin
							new_game_armed = 1'b0;
							cmd.kind = KIND_NEW_GAME;
						end
					end else if (w[0] >= CH_1 && w[0] <= CH_9 && w[1] >= CH_1 && w[1] <= CH_9 &&
							w[2] >= CH_0 && w[2] <= CH_9 && w[3] >= CH_0 && w[3] <= CH_7) begin
						r = w[0] - CH_0;
						k = w[1] - CH_0;
						v = w[2] - CH_0;
						s = w[3] - CH_0;
						if (((r + k + v) & 7) == s) begin
							cmd.kind = KIND_MOVE;
							cmd.row = DIGIT_W'(r);
							cmd.column = DIGIT_W'(k);
							cmd.value = DIGIT_W'(v);
						end
					end
					frame_open = 1'b0;
				end
			end
			pending_cmds.push_back(cmd);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				errors++;
				if (mismatches <= 10)
					$display("mismatch in %s: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_command(logic [39:0] data, logic [1:0] user);
			cmd_t want;
			if (pending_cmds.size() == 0) begin
				mismatches++;
				errors++;
				if (mismatches <= 10)
					$display("command transfer with nothing pending: tuser %0d tdata %h",
						user, data);
				return;
			end
			want = pending_cmds.pop_front();
			compare("command_kind", want.kind, user);
			compare("move_row", want.row, data[3:0]);
			compare("move_column", want.column, data[7:4]);
			compare("move_value", want.value, data[11:8]);
			compare("idle_alarm_ms", want.alarm_ms, data[34:12]);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [TIMEOUT_W-1:0] cfg_data;

	command_tracker tracker;
	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	int unsigned    chars_sent;
	int unsigned    cycles;

	framed_command_decoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_command(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_char(c);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] ms);
		cfg_valid <= 1'b1;
		cfg_data <= ms;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_timeout(ms);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one frame or a short run of noise, mostly well formed with random content
	task automatic send_random_sequence();
		logic [7:0]  seq [$];
		int unsigned pick, r, k, v, s, n, p;
		pick = $urandom_range(99);
		seq.push_back(CH_OPEN);
		if (pick < 14) begin
			seq.push_back(CH_R);
			seq.push_back(CH_S);
			seq.push_back(CH_T);
		end else if (pick < 22) begin
			seq.push_back(CH_N);
			seq.push_back(CH_E);
			seq.push_back(CH_W);
		end else if (pick < 58) begin
			r = $urandom_range(1, 9);
			k = $urandom_range(1, 9);
			v = $urandom_range(0, 9);
			s = (r + k + v) & 7;
			seq.push_back(8'(CH_0 + r));
			seq.push_back(8'(CH_0 + k));
			seq.push_back(8'(CH_0 + v));
			seq.push_back(8'(CH_0 + s));
		end else if (pick < 70) begin
			seq.push_back(8'(CH_0 + $urandom_range(0, 9)));
			seq.push_back(8'(CH_0 + $urandom_range(0, 9)));
			seq.push_back(8'(CH_0 + $urandom_range(0, 9)));
			seq.push_back(8'(CH_0 + $urandom_range(0, 9)));
		end else if (pick < 80) begin
			n = $urandom_range(0, 12);
			for (int i = 0; i < n; i++)
				seq.push_back(8'($urandom_range(255)));
		end else begin
			seq.delete();
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				if (pick < 88)
					seq.push_back(8'($urandom_range(255)));
				else if (pick < 94)
					seq.push_back(CH_CLOSE);
				else
					seq.push_back(CH_DELETE);
			end
		end
		if (pick < 80) begin
			seq.push_back(CH_CLOSE);
			// a typo corrected by delete somewhere inside the frame
			if ($urandom_range(3) == 0) begin
				p = $urandom_range(1, seq.size() - 1);
				seq.insert(p, CH_DELETE);
				seq.insert(p, 8'(8'h41 + $urandom_range(25)));
			end
		end
		foreach (seq[i])
			send_char(seq[i]);
	endtask

	task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned goal);
		int unsigned start;
		bit          paused;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = chars_sent;
		paused = 1'b0;
		while (chars_sent - start < goal) begin
			send_random_sequence();
			if (!paused && chars_sent - start > goal / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		chars_sent = 0;
		cycles = 0;
		tracker = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part with the timeout left at its reset value
		send_char(CH_DELETE);
		send_char(8'h00);
		send_char(8'hFF);
		send_text("#RST!");
		send_text("#NEW!");
		send_text("#NEW!");
		send_text("#9993!");
		send_char(CH_DELETE);
		send_char(CH_CLOSE);
		send_text("#1235!");
		wait_drained();

		write_timeout('0);
		run_phase(19, 68, ITEM_GOAL / 3);
		write_timeout({TIMEOUT_W{1'b1}});
		run_phase(68, 19, ITEM_GOAL / 3);
		write_timeout(TIMEOUT_W'($urandom_range(1, (1 << TIMEOUT_W) - 2)));
		run_phase(0, 0, ITEM_GOAL / 3);

		repeat (SETTLE_CYC) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
